@@ rtl/tke_pkg.sv @@
// Package for the touch key event tracker: sizes, sensor bit map,
// operation and register codes, and the structs shared by the modules.
// No dependencies.
package tke_pkg;

    localparam int KEY_COUNT   = 4;
    localparam int MAX_KEYS    = 8;
    localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int TICK_W      = 32;
    localparam int EVENT_W     = 4;
    localparam int REG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Sensor status bit that carries each key
    typedef logic [2:0] sensor_sel_t;
    localparam sensor_sel_t SENSOR_BIT [MAX_KEYS] = '{
        3'd0, 3'd4, 3'd1, 3'd3, 3'd2, 3'd5, 3'd6, 3'd7
    };

    // Operation codes
    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [REG_INDEX_W-1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_REPEAT_DELAY = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_LAST_REPEAT  = 2'd2;
    localparam logic [REG_INDEX_W-1:0] REG_ESCAPE_KEY   = 2'd3;

    // Register reset values
    localparam logic [TICK_W-1:0] LONG_PRESS_RST   = 32'd2000;
    localparam logic [TICK_W-1:0] REPEAT_DELAY_RST = 32'd1000;
    localparam logic [1:0]        LAST_REPEAT_RST  = 2'd1;
    localparam logic [1:0]        ESCAPE_KEY_RST   = 2'd2;

    typedef struct packed {
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] repeat_delay_ticks;
        logic [1:0]        last_repeat_key;
        logic [1:0]        escape_key;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        touch_bits;
        logic              read_ok;
        logic [TICK_W-1:0] now_ticks;
        logic              standby;
        logic [3:0]        key_index;
        logic [3:0]        clear_mask;
    } item_t;

    typedef struct packed {
        logic [KEY_COUNT-1:0][TICK_W-1:0] release_time;
        logic [KEY_COUNT-1:0]             long_flag;
        logic [KEY_COUNT-1:0]             pressed;
        logic [EVENT_W-1:0]               event_bits;
    } key_state_t;

    typedef struct packed {
        logic [EVENT_W-1:0] events;
        logic [EVENT_W-1:0] key_state;
        logic               long_press;
        logic               rearm_pulse;
        logic               wake_request;
    } result_t;

endpackage

@@ rtl/tke_if.sv @@
// Valid/ready channel interfaces for the touch key event tracker.
// Input items and result items; depends on tke_pkg.
interface tke_in_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [7:0]            touch_bits;
    logic                  read_ok;
    logic [tke_pkg::TICK_W-1:0] now_ticks;
    logic                  standby;
    logic [3:0]            key_index;
    logic [3:0]            clear_mask;

    modport source (output valid, operation, touch_bits, read_ok, now_ticks,
                    standby, key_index, clear_mask, input ready);
    modport sink   (input valid, operation, touch_bits, read_ok, now_ticks,
                    standby, key_index, clear_mask, output ready);
endinterface

interface tke_out_if;
    logic                          valid;
    logic                          ready;
    logic [tke_pkg::EVENT_W-1:0]   events;
    logic [tke_pkg::EVENT_W-1:0]   key_state;
    logic                          long_press;
    logic                          rearm_pulse;
    logic                          wake_request;

    modport source (output valid, events, key_state, long_press, rearm_pulse,
                    wake_request, input ready);
    modport sink   (input valid, events, key_state, long_press, rearm_pulse,
                    wake_request, output ready);
endinterface

@@ rtl/tke_cfg_regs.sv @@
// Configuration registers of the touch key event tracker.
// Plain write port; depends on tke_pkg.
module tke_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [tke_pkg::REG_INDEX_W-1:0]   index,
    input  logic [tke_pkg::CFG_DATA_W-1:0]    data,
    output tke_pkg::cfg_t                     cfg
);
    import tke_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks   <= LONG_PRESS_RST;
            cfg_reg.repeat_delay_ticks <= REPEAT_DELAY_RST;
            cfg_reg.last_repeat_key    <= LAST_REPEAT_RST;
            cfg_reg.escape_key         <= ESCAPE_KEY_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_LONG_PRESS:   cfg_reg.long_press_ticks   <= data[TICK_W-1:0];
                REG_REPEAT_DELAY: cfg_reg.repeat_delay_ticks <= data[TICK_W-1:0];
                REG_LAST_REPEAT:  cfg_reg.last_repeat_key    <= data[1:0];
                REG_ESCAPE_KEY:   cfg_reg.escape_key         <= data[1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tke_key_logic.sv @@
// Per-item key logic: next key state and result for one registered item.
// Purely combinational; depends on tke_pkg.
module tke_key_logic (
    input  tke_pkg::item_t      item,
    input  tke_pkg::cfg_t       cfg,
    input  tke_pkg::key_state_t cur,
    output tke_pkg::key_state_t nxt,
    output tke_pkg::result_t    res
);
    import tke_pkg::*;

    logic [7:0]           bits;
    logic                 stby;
    logic                 on;
    logic [TICK_W-1:0]    held;
    logic                 fast;
    logic                 query_ok;
    logic [KEY_IDX_W-1:0] qkey;
    logic                 lp;
    logic                 rearm;
    logic                 wake;

    assign bits     = item.read_ok ? item.touch_bits : 8'd0;
    assign query_ok = item.key_index < 4'(KEY_COUNT);
    assign qkey     = item.key_index[KEY_IDX_W-1:0];

    always_comb
    begin
        nxt   = cur;
        lp    = 1'b0;
        rearm = 1'b0;
        wake  = 1'b0;
        stby  = item.standby;
        on    = 1'b0;
        held  = '0;
        fast  = 1'b0;
        unique case (item.operation)
            OP_SCAN:
            begin
                // keys in index order; a wake leaves standby for later keys
                for (int i = 0; i < KEY_COUNT; i++)
                begin
                    on = bits[SENSOR_BIT[i]];
                    if (!on)
                        nxt.release_time[i] = item.now_ticks;
                    held = item.now_ticks - nxt.release_time[i];
                    nxt.long_flag[i] = held > cfg.long_press_ticks;
                    fast = (3'(i) <= {1'b0, cfg.last_repeat_key}) && on
                           && (held > cfg.repeat_delay_ticks);
                    if (on && (fast || !cur.pressed[i]))
                    begin
                        rearm = 1'b1;
                        if (stby)
                        begin
                            if (3'(i) != {1'b0, cfg.escape_key})
                            begin
                                wake = 1'b1;
                                stby = 1'b0;
                            end
                        end
                        else if (i < EVENT_W)
                        begin
                            nxt.event_bits[i % EVENT_W] = 1'b1;
                        end
                    end
                    nxt.pressed[i] = on;
                end
            end
            OP_QUERY:
            begin
                if (query_ok && cur.pressed[qkey] && cur.long_flag[qkey])
                begin
                    lp = 1'b1;
                    nxt.release_time[qkey] = '0;
                    nxt.long_flag[qkey]    = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                nxt.event_bits = cur.event_bits & ~item.clear_mask;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res              = '0;
        res.events       = nxt.event_bits;
        res.long_press   = lp;
        res.rearm_pulse  = rearm;
        res.wake_request = wake;
        for (int i = 0; i < EVENT_W; i++)
        begin
            if (i < KEY_COUNT)
                res.key_state[i] = nxt.pressed[i % KEY_COUNT];
        end
    end

endmodule

@@ rtl/touch_key_event_tracker.sv @@
// Top level of the touch key event tracker: input register, key state,
// result register and configuration registers.
// Depends on tke_pkg, tke_if, tke_cfg_regs and tke_key_logic.
//
//  channel   | role   | item
//  ----------+--------+-----------------------------------------------
//  in_item   | sink   | scan / query / clear request
//  out_item  | source | events, key_state, long_press, rearm, wake
//  cfg_*     | write  | four config registers, no read-back
//
// Two-stage flow: an accepted item lands in the input register; once the
// result slot is free, the key logic updates the key state and loads the
// result register. One item per cycle sustained while results are taken.
// The input register advances whenever the result register is empty or
// being taken; a waiting result stalls the input only once the input
// register also holds an item.
// rst_n clears all key state, pending events and valid flags, and loads
// the config registers with their defaults.
module touch_key_event_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    tke_in_if.sink                            in_item,
    tke_out_if.source                         out_item,
    input  logic                              cfg_wr_en,
    input  logic [tke_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  logic [tke_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tke_pkg::*;

    cfg_t       cfg;
    item_t      item_reg;
    logic       item_valid_reg;
    key_state_t state_reg;
    key_state_t state_next;
    result_t    result_reg;
    result_t    result_next;
    logic       out_valid_reg;
    logic       advance;
    logic       in_fire;

    tke_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    tke_key_logic u_logic (
        .item (item_reg),
        .cfg  (cfg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // item in input register moves on when the result slot frees up
    assign advance        = item_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready  = !item_valid_reg || advance;
    assign in_fire        = in_item.valid && in_item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (in_fire)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_item.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.operation  <= in_item.operation;
            item_reg.touch_bits <= in_item.touch_bits;
            item_reg.read_ok    <= in_item.read_ok;
            item_reg.now_ticks  <= in_item.now_ticks;
            item_reg.standby    <= in_item.standby;
            item_reg.key_index  <= in_item.key_index;
            item_reg.clear_mask <= in_item.clear_mask;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_item.valid        = out_valid_reg;
    assign out_item.events       = result_reg.events;
    assign out_item.key_state    = result_reg.key_state;
    assign out_item.long_press   = result_reg.long_press;
    assign out_item.rearm_pulse  = result_reg.rearm_pulse;
    assign out_item.wake_request = result_reg.wake_request;

    // a wake only comes from a detected press
    a_wake_needs_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && out_item.wake_request |-> out_item.rearm_pulse)
        else $error("wake without rearm");

    // a query answer never comes with scan flags
    a_query_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && out_item.long_press
        |-> !out_item.rearm_pulse && !out_item.wake_request)
        else $error("long press together with scan flags");

    // only a scan changes which keys are pressed
    a_pressed_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item_reg.operation != OP_SCAN) |=> $stable(state_reg.pressed))
        else $error("pressed keys changed outside a scan");

    // a held item stays put while the result slot is blocked
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("input register lost an item");

endmodule

@@ bench/touch_key_event_tracker_tb.sv @@
`timescale 1ns / 1ps
// Testbench for touch_key_event_tracker: directed and random key items,
// checked against a local prediction of key state, events and flags.
// Depends on tke_pkg, tke_if and the tracker RTL.
module touch_key_event_tracker_tb;

    import tke_pkg::*;

    // Operation code the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles with no handshake on any port before the run is declared hung.
    // The limit sits well above the long output hold.
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_wr_en;
    logic [REG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tke_in_if  in_if ();
    tke_out_if out_if ();

    touch_key_event_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_if),
        .out_item  (out_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predicted block state and configuration
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]  rel_tick [KEY_COUNT];  // tick of last release per key
    logic [KEY_COUNT-1:0] held_long;           // long-press flag per key
    logic [KEY_COUNT-1:0] pressed_pred;        // key pressed at last scan
    logic [EVENT_W-1:0]   pend_events;

    logic [TICK_W-1:0] long_ticks_cfg;
    logic [TICK_W-1:0] repeat_ticks_cfg;
    logic [1:0]        last_repeat_cfg;
    logic [1:0]        escape_cfg;

    result_t expected_results [$];

    // Stimulus session: which keys the "finger" holds and the tick clock
    logic [KEY_COUNT-1:0] sess_keys;
    logic [TICK_W-1:0]    sess_ticks;

    // Shared control between the sender, the result sink and the tests
    bit no_idle;               // both sides run without gaps
    int result_hold_cycles;    // one-shot long hold request for the sink

    int mismatches;
    int items_sent, scans_sent, queries_sent, clears_sent;
    int results_seen, rearm_seen, wake_seen, long_hits;
    int quiet_cycles;

    // Work out the result of one item and advance the predicted state.
    // Keys are walked in index order; a wake in standby ends standby for
    // the keys that follow in the same scan.
    function automatic result_t advance_key_tracker(input item_t it);
        result_t           r;
        logic [7:0]        bits;
        logic [TICK_W-1:0] held;
        logic              on;
        logic              fast;
        logic              stby;
        int                k;
        r = '0;
        bits = it.read_ok ? it.touch_bits : 8'h00;
        stby = it.standby;
        case (it.operation)
            OP_SCAN:
            begin
                for (k = 0; k < KEY_COUNT; k++)
                begin
                    on = bits[SENSOR_BIT[k]];
                    if (!on)
                        rel_tick[k] = it.now_ticks;
                    held = it.now_ticks - rel_tick[k];  // wraps mod 2^32
                    held_long[k] = (held > long_ticks_cfg);
                    fast = (k <= last_repeat_cfg) && on && (held > repeat_ticks_cfg);
                    if (on && (fast || !pressed_pred[k]))
                    begin
                        r.rearm_pulse = 1'b1;
                        if (stby)
                        begin
                            if (k != escape_cfg)
                            begin
                                r.wake_request = 1'b1;
                                stby = 1'b0;
                            end
                        end
                        else if (k < EVENT_W)
                        begin
                            pend_events[k] = 1'b1;
                        end
                    end
                    pressed_pred[k] = on;
                end
            end
            OP_QUERY:
            begin
                // a hit consumes the flag and restarts the hold from tick zero
                if (it.key_index < KEY_COUNT && pressed_pred[it.key_index]
                    && held_long[it.key_index])
                begin
                    r.long_press = 1'b1;
                    rel_tick[it.key_index] = '0;
                    held_long[it.key_index] = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                pend_events = pend_events & ~it.clear_mask;
            end
            default:
            begin
            end
        endcase
        r.events = pend_events;
        for (k = 0; k < KEY_COUNT && k < EVENT_W; k++)
            r.key_state[k] = pressed_pred[k];
        return r;
    endfunction

    function automatic logic [7:0] touch_for_keys(input logic [KEY_COUNT-1:0] keys);
        logic [7:0] t;
        int         k;
        t = '0;
        for (k = 0; k < KEY_COUNT; k++)
            t[SENSOR_BIT[k]] = keys[k];
        return t;
    endfunction

    function automatic item_t make_key_item(input logic [1:0] op, input logic [7:0] touch,
                                            input logic ok, input logic [TICK_W-1:0] now,
                                            input logic stby, input logic [3:0] kidx,
                                            input logic [3:0] mask);
        item_t it;
        it.operation  = op;
        it.touch_bits = touch;
        it.read_ok    = ok;
        it.now_ticks  = now;
        it.standby    = stby;
        it.key_index  = kidx;
        it.clear_mask = mask;
        return it;
    endfunction

    // Mostly a plausible session: keys held across scans while the tick
    // count climbs, so long presses and repeats actually happen. One item
    // in ten is pure noise.
    function automatic item_t next_key_item();
        item_t it;
        int    pick;
        int    k;
        if ($urandom_range(0, 9) == 0)
        begin
            it.operation  = 2'($urandom_range(0, 3));
            it.touch_bits = 8'($urandom);
            it.read_ok    = 1'($urandom);
            it.now_ticks  = $urandom;
            it.standby    = 1'($urandom);
            it.key_index  = 4'($urandom);
            it.clear_mask = 4'($urandom);
            return it;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            it.operation = OP_SCAN;
            for (k = 0; k < KEY_COUNT; k++)
                if ($urandom_range(0, 3) == 0)
                    sess_keys[k] = ~sess_keys[k];
            sess_ticks += ($urandom_range(0, 15) == 0) ? $urandom_range(0, 6000)
                                                       : $urandom_range(0, 700);
        end
        else if (pick < 85)
            it.operation = OP_QUERY;
        else if (pick < 97)
            it.operation = OP_CLEAR;
        else
            it.operation = OP_UNUSED;
        // sensor bits no key reads carry random noise
        it.touch_bits = touch_for_keys(sess_keys) | (8'($urandom) & ~touch_for_keys('1));
        it.read_ok    = ($urandom_range(0, 19) != 0);
        it.now_ticks  = sess_ticks;
        it.standby    = ($urandom_range(0, 4) == 0);
        it.key_index  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(4, 15))
                                                    : 4'($urandom_range(0, 3));
        it.clear_mask = 4'($urandom);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: mismatch on %s: expected %0h, got %0h",
                     $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Sender: one item, with a random gap unless gaps are off.
    // valid stays high between back-to-back items (no drop-and-raise).
    // ------------------------------------------------------------------
    task automatic send_key_item(input item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.operation  <= it.operation;
        in_if.touch_bits <= it.touch_bits;
        in_if.read_ok    <= it.read_ok;
        in_if.now_ticks  <= it.now_ticks;
        in_if.standby    <= it.standby;
        in_if.key_index  <= it.key_index;
        in_if.clear_mask <= it.clear_mask;
        do @(posedge clk); while (!in_if.ready);
        expected_results.push_back(advance_key_tracker(it));
        items_sent++;
        case (it.operation)
            OP_SCAN:  scans_sent++;
            OP_QUERY: queries_sent++;
            OP_CLEAR: clears_sent++;
            default:  ;
        endcase
    endtask

    // Stop offering items and wait for every outstanding result, then let the
    // two-stage pipeline settle.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tracker_reg(input logic [REG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LONG_PRESS:   long_ticks_cfg   = val;
            REG_REPEAT_DELAY: repeat_ticks_cfg = val;
            REG_LAST_REPEAT:  last_repeat_cfg  = val[1:0];
            REG_ESCAPE_KEY:   escape_cfg       = val[1:0];
            default:          ;
        endcase
    endtask

    // Registers only change with the block idle
    task automatic apply_tracker_config(input logic [TICK_W-1:0] long_t,
                                        input logic [TICK_W-1:0] rep_t,
                                        input logic [1:0] last_rep, input logic [1:0] esc);
        drain_results();
        write_tracker_reg(REG_LONG_PRESS, long_t);
        write_tracker_reg(REG_REPEAT_DELAY, rep_t);
        write_tracker_reg(REG_LAST_REPEAT, {30'd0, last_rep});
        write_tracker_reg(REG_ESCAPE_KEY, {30'd0, esc});
    endtask

    task automatic run_key_sessions(input int count, input logic [TICK_W-1:0] start_ticks);
        int n;
        sess_ticks = start_ticks;
        for (n = 0; n < count; n++)
        begin
            // gap-free stretches now and then
            if (n % 20 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_key_item(next_key_item());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk through the documented behaviors at default settings:
    // out-of-range queries, failed reads, fresh presses, repeats, long
    // press hit and its consumption, escape key in standby, wake ending
    // standby mid-scan, tick wrap, the unused opcode and clear masks.
    task automatic test_directed_cases();
        send_key_item(make_key_item(OP_QUERY, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_QUERY, 8'h00, 1'b1, 32'd0, 1'b0, 4'd15, 4'h0));
        // failed read: all keys count as released
        send_key_item(make_key_item(OP_SCAN, 8'hFF, 1'b0, 32'd100, 1'b0, 4'd0, 4'h0));
        // every key pressed fresh
        send_key_item(make_key_item(OP_SCAN, 8'hFF, 1'b1, 32'd200, 1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_CLEAR, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'hF));
        // held past repeat delay: repeat keys fire again
        send_key_item(make_key_item(OP_SCAN, 8'hFF, 1'b1, 32'd1300, 1'b0, 4'd0, 4'h0));
        // held past long-press threshold
        send_key_item(make_key_item(OP_SCAN, 8'hFF, 1'b1, 32'd2400, 1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_QUERY, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_QUERY, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_QUERY, 8'h00, 1'b1, 32'd0, 1'b0, 4'd3, 4'h0));
        send_key_item(make_key_item(OP_QUERY, 8'h00, 1'b1, 32'd0, 1'b0, 4'd4, 4'h0));
        send_key_item(make_key_item(OP_CLEAR, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'b0101));
        send_key_item(make_key_item(OP_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                                    4'd15, 4'hF));
        // release all, then the escape key alone in standby: rearm, no wake
        send_key_item(make_key_item(OP_SCAN, 8'h00, 1'b1, 32'd2500, 1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_SCAN, touch_for_keys(4'b0100), 1'b1, 32'd2600,
                                    1'b1, 4'd0, 4'h0));
        // key 0 wakes; key 1 in the same scan then sets its event
        send_key_item(make_key_item(OP_SCAN, touch_for_keys(4'b0111), 1'b1, 32'd2700,
                                    1'b1, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_CLEAR, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'hF));
        // release near the top of the tick range, press after the wrap
        send_key_item(make_key_item(OP_SCAN, 8'h00, 1'b1, 32'hFFFF_FF00, 1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_SCAN, touch_for_keys(4'hF), 1'b1, 32'h0000_0800,
                                    1'b0, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_QUERY, 8'h00, 1'b1, 32'd0, 1'b0, 4'd1, 4'h0));
        send_key_item(make_key_item(OP_CLEAR, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'h0));
        // key 1 now elapses from tick zero: huge hold at the top of the range
        send_key_item(make_key_item(OP_SCAN, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd0, 4'h0));
        send_key_item(make_key_item(OP_CLEAR, 8'h00, 1'b1, 32'd0, 1'b0, 4'd0, 4'hF));
    endtask

    // Zero thresholds with every key repeating, then maximal thresholds
    // with only key 0 repeating, then a random middle setting.
    task automatic test_threshold_extremes();
        apply_tracker_config('0, '0, 2'd3, 2'd0);
        run_key_sessions(60, $urandom);
        apply_tracker_config('1, '1, 2'd0, 2'd3);
        run_key_sessions(60, $urandom);
        apply_tracker_config($urandom_range(1, 3000), $urandom_range(1, 2000),
                             2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        run_key_sessions(60, $urandom);
    endtask

    task automatic test_random_sessions();
        apply_tracker_config(LONG_PRESS_RST, REPEAT_DELAY_RST, LAST_REPEAT_RST,
                             ESCAPE_KEY_RST);
        run_key_sessions(200, $urandom);
    endtask

    // Hold the output long enough for the block to fill and stall its
    // input while the sender keeps pushing back to back.
    task automatic test_output_backpressure();
        int n;
        result_hold_cycles = LONG_HOLD;
        no_idle = 1'b1;
        for (n = 0; n < 30; n++)
            send_key_item(next_key_item());
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stall per item, optional long hold
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (result_hold_cycles > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (result_hold_cycles) @(posedge clk);
                result_hold_cycles = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!out_if.valid && result_hold_cycles == 0);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted item against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding (events)", 32'd0,
                                32'(out_if.events));
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_if.events !== want.events)
                    report_mismatch("events", 32'(want.events), 32'(out_if.events));
                if (out_if.key_state !== want.key_state)
                    report_mismatch("key_state", 32'(want.key_state),
                                    32'(out_if.key_state));
                if (out_if.long_press !== want.long_press)
                    report_mismatch("long_press", 32'(want.long_press),
                                    32'(out_if.long_press));
                if (out_if.rearm_pulse !== want.rearm_pulse)
                    report_mismatch("rearm_pulse", 32'(want.rearm_pulse),
                                    32'(out_if.rearm_pulse));
                if (out_if.wake_request !== want.wake_request)
                    report_mismatch("wake_request", 32'(want.wake_request),
                                    32'(out_if.wake_request));
                rearm_seen += int'(want.rearm_pulse);
                wake_seen  += int'(want.wake_request);
                long_hits  += int'(want.long_press);
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, expected_results.size());
                $display("FAIL touch_key_event_tracker");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_if.valid      = 1'b0;
        in_if.operation  = OP_SCAN;
        in_if.touch_bits = '0;
        in_if.read_ok    = 1'b0;
        in_if.now_ticks  = '0;
        in_if.standby    = 1'b0;
        in_if.key_index  = '0;
        in_if.clear_mask = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;

        // predicted state after reset
        for (int k = 0; k < KEY_COUNT; k++)
            rel_tick[k] = '0;
        held_long        = '0;
        pressed_pred     = '0;
        pend_events      = '0;
        long_ticks_cfg   = LONG_PRESS_RST;
        repeat_ticks_cfg = REPEAT_DELAY_RST;
        last_repeat_cfg  = LAST_REPEAT_RST;
        escape_cfg       = ESCAPE_KEY_RST;
        sess_keys        = '0;
        sess_ticks       = '0;
        no_idle          = 1'b0;
        result_hold_cycles = 0;
        mismatches = 0;
        items_sent = 0; scans_sent = 0; queries_sent = 0; clears_sent = 0;
        results_seen = 0; rearm_seen = 0; wake_seen = 0; long_hits = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_threshold_extremes();
        test_random_sessions();
        test_output_backpressure();
        // a second random pass that crosses the tick wrap
        run_key_sessions(120, 32'hFFFF_8000);

        drain_results();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered (count)", 32'd0,
                            expected_results.size());

        $display("Covered %0d items (%0d scans, %0d queries, %0d clears) over 5 settings;",
                 items_sent, scans_sent, queries_sent, clears_sent);
        $display("%0d results checked: %0d rearm, %0d wake, %0d long-press hits, %0d mismatches",
                 results_seen, rearm_seen, wake_seen, long_hits, mismatches);
        if (mismatches == 0)
            $display("PASS touch_key_event_tracker");
        else
            $display("FAIL touch_key_event_tracker");
        $finish;
    end

endmodule
